>>> hw/rtl/i2r_pkg.sv
// Package with the shared types and the Roman numeral token table.
`default_nettype none

package i2r_pkg;

    // Widths of the value and of one ASCII letter.
    localparam int VALUE_W = 12;
    localparam int CHAR_W  = 7;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;

    // Largest value that has a standard numeral; larger inputs saturate here.
    localparam t_value VALUE_MAX = 12'd3999;

    // ASCII codes of the seven Roman letters.
    localparam t_char CH_M = 7'h4D;
    localparam t_char CH_D = 7'h44;
    localparam t_char CH_C = 7'h43;
    localparam t_char CH_L = 7'h4C;
    localparam t_char CH_X = 7'h58;
    localparam t_char CH_V = 7'h56;
    localparam t_char CH_I = 7'h49;

    // Greedy token table, largest weight first. Subtractive tokens carry two letters.
    localparam int TOKEN_N = 13;
    localparam int IDX_W   = $clog2(TOKEN_N);

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx TOKEN_LAST = IDX_W'(TOKEN_N - 1);

    localparam t_value WEIGHT [TOKEN_N] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40,   12'd10,  12'd9,   12'd5,   12'd4,   12'd1
    };

    localparam t_char FIRST_CH [TOKEN_N] = '{
        CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L,
        CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
    };

    localparam t_char SECOND_CH [TOKEN_N] = '{
        CH_M, CH_M, CH_D, CH_D, CH_C, CH_C, CH_L,
        CH_L, CH_X, CH_X, CH_V, CH_V, CH_I
    };

    localparam logic [TOKEN_N-1:0] IS_PAIR = 13'b0_1010_1010_1010;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic   ge;
        logic   zero;
        t_value diff;
    } t_cmp_res;

endpackage

`default_nettype wire

>>> hw/rtl/i2r_cmpsub.sv
// Shared compare and subtract unit: tests the remainder against one token weight.
`default_nettype none

module i2r_cmpsub (
    input  wire i2r_pkg::t_value   i_rem,
    input  wire i2r_pkg::t_value   i_weight,
    output i2r_pkg::t_cmp_res      o_res
);
    import i2r_pkg::*;

    logic [VALUE_W:0] wide;

    // One subtractor serves both the compare and the new remainder.
    assign wide       = {1'b0, i_rem} - {1'b0, i_weight};
    assign o_res.ge   = ~wide[VALUE_W];
    assign o_res.diff = wide[VALUE_W-1:0];
    assign o_res.zero = (wide[VALUE_W-1:0] == '0);

endmodule

`default_nettype wire

>>> hw/rtl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
//
// Usage: drive i_value and pulse start while busy is low; that edge accepts
// one beat. Values above 3999 are saturated to 3999; a value of 0 is accepted
// and produces no letters, and busy stays low.
// Letters come out most significant first, one beat per cycle at most, each
// shown on o_symbol/o_last for exactly one cycle with o_strobe high. o_last
// marks the final letter of the numeral. The receiver cannot stall the block.
// Method: a sequencer walks a 13-entry weight table, from 1000 down to 1,
// through one shared compare and subtract unit. Each cycle either emits a
// letter or skips one weight that no longer fits. The first letter is formed
// in the run state and registered onto o_symbol with o_strobe. The slowest
// value is 3888, with 15 letters and 12 skipped weights, and a new value is
// taken only after busy falls with the final beat of the last one.
// busy is high from the accept until the cycle the final beat is shown, so
// the next value can be accepted on the edge that ends the final beat.
// Reset clears the sequencer and the strobe; no value is kept between items.
`default_nettype none

module integer_to_roman_numeral (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire i2r_pkg::t_value i_value,
    output logic                 busy,
    output logic                 o_strobe,
    output i2r_pkg::t_char       o_symbol,
    output logic                 o_last
);
    import i2r_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_PAIR = 2'd2;

    logic [1:0] r_state, n_state;
    t_idx       r_idx, n_idx;
    t_value     r_rem, n_rem;
    t_char      r_pend, n_pend;
    logic       r_pend_last, n_pend_last;
    logic       r_strobe, n_strobe;
    logic       r_last, n_last;
    t_char      r_symbol, n_symbol;
    t_cmp_res   cmp;

    // Shared unit compares the remainder with the current table weight.
    i2r_cmpsub u_cmpsub (
        .i_rem    (r_rem),
        .i_weight (WEIGHT[r_idx]),
        .o_res    (cmp)
    );

    // Sequencer next-state and beat generation.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_strobe    = 1'b0;
        n_last      = 1'b0;
        n_symbol    = r_symbol;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rem   = (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
                    n_idx   = '0;
                    n_state = (i_value == '0) ? S_IDLE : S_RUN;
                end
            end
            S_RUN: begin
                if (cmp.ge) begin
                    n_rem    = cmp.diff;
                    n_strobe = 1'b1;
                    n_symbol = FIRST_CH[r_idx];
                    if (IS_PAIR[r_idx]) begin
                        n_pend      = SECOND_CH[r_idx];
                        n_pend_last = cmp.zero;
                        n_state     = S_PAIR;
                    end else begin
                        n_last = cmp.zero;
                        if (cmp.zero) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_idx != TOKEN_LAST) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PAIR: begin
                // A subtractive token is used at most once, so move past it too.
                n_strobe = 1'b1;
                n_symbol = r_pend;
                n_last   = r_pend_last;
                n_state  = r_pend_last ? S_IDLE : S_RUN;
                if (r_idx != TOKEN_LAST) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_pend      <= n_pend;
        r_pend_last <= n_pend_last;
        r_symbol    <= n_symbol;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/i2r_checker.sv
// Port-level checker for the converter and its bind to the top level.
`default_nettype none

module i2r_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire i2r_pkg::t_value i_value,
    input  wire                  busy,
    input  wire                  o_strobe,
    input  wire i2r_pkg::t_char  o_symbol,
    input  wire                  o_last
);
    import i2r_pkg::*;

    // A value of zero is taken without starting any work.
    a_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_value == '0) |=> !busy)
        else $error("zero value started a conversion");

    // A nonzero value keeps the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_value != '0) |=> busy)
        else $error("nonzero value did not start a conversion");

    // Letters only follow a cycle in which the block was working.
    a_beat_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("beat shown outside a conversion");

    // The final beat ends the conversion.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("block still busy on the final beat");

    // Every beat carries a Roman letter.
    a_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_symbol == CH_M || o_symbol == CH_D || o_symbol == CH_C ||
                      o_symbol == CH_L || o_symbol == CH_X || o_symbol == CH_V ||
                      o_symbol == CH_I))
        else $error("beat carries a code that is no Roman letter");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_value  (i_value),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_symbol (o_symbol),
    .o_last   (o_last)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the integer to Roman numeral converter.
`timescale 1ns / 100ps

module tb_top;
    import i2r_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 350;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned WATCHDOG_LIMIT = 400;

    typedef struct {
        t_char symbol;
        logic  is_last;
    } t_roman_letter;

    // Scoreboard: expands each accepted value into the letters it must produce
    // and compares every letter beat against the oldest one still owed.
    class numeral_scoreboard;
        t_roman_letter letters_due[$];
        int unsigned   mismatches;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void push_letter(t_char c);
            t_roman_letter item;
            item.symbol  = c;
            item.is_last = 1'b0;
            letters_due = {letters_due, item};
        endfunction

        function void note_value(t_value v);
            int unsigned n;
            int unsigned digit;
            int unsigned divisor;
            int unsigned pos;
            int unsigned k;
            int unsigned first_idx;
            t_char       one_ch;
            t_char       five_ch;
            t_char       ten_ch;
            n = (v > VALUE_MAX) ? int'(VALUE_MAX) : int'(v);
            first_idx = letters_due.size();
            // Thousands are plain repeated M.
            for (k = 0; k < n / 1000; k++) begin
                push_letter(CH_M);
            end
            // Hundreds, tens and units share one pattern with their own letters.
            for (pos = 1; pos < 4; pos++) begin
                case (pos)
                    1: begin
                        one_ch = CH_C; five_ch = CH_D; ten_ch = CH_M; divisor = 100;
                    end
                    2: begin
                        one_ch = CH_X; five_ch = CH_L; ten_ch = CH_C; divisor = 10;
                    end
                    default: begin
                        one_ch = CH_I; five_ch = CH_V; ten_ch = CH_X; divisor = 1;
                    end
                endcase
                digit = (n / divisor) % 10;
                if (digit == 9) begin
                    push_letter(one_ch);
                    push_letter(ten_ch);
                end else if (digit >= 5) begin
                    push_letter(five_ch);
                    for (k = 5; k < digit; k++) begin
                        push_letter(one_ch);
                    end
                end else if (digit == 4) begin
                    push_letter(one_ch);
                    push_letter(five_ch);
                end else begin
                    for (k = 0; k < digit; k++) begin
                        push_letter(one_ch);
                    end
                end
            end
            // Zero produces nothing, so only mark a final letter if one was added.
            if (letters_due.size() > first_idx) begin
                letters_due[letters_due.size() - 1].is_last = 1'b1;
            end
        endfunction

        function void check_letter(t_char sym, logic is_last);
            t_roman_letter want;
            if (letters_due.size() == 0) begin
                flag($sformatf("Unexpected letter beat: symbol=0x%h last=%b", sym, is_last));
                return;
            end
            want = letters_due.pop_front();
            if (sym !== want.symbol || is_last !== want.is_last) begin
                flag($sformatf("Letter mismatch: expected %c (0x%h) last=%b, got 0x%h last=%b",
                               want.symbol, want.symbol, want.is_last, sym, is_last));
            end
        endfunction
    endclass

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    t_value i_value = '0;
    logic   busy;
    logic   o_strobe;
    t_char  o_symbol;
    logic   o_last;

    int unsigned       idle_cycles = 0;
    numeral_scoreboard sb = new;

    integer_to_roman_numeral dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_value  (i_value),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Monitor: letter beats are checked before a value accepted on the same
    // edge is noted, since that letter belongs to an earlier value.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_letter(o_symbol, o_last);
            end
            if (start && !busy) begin
                sb.note_value(i_value);
            end
        end
    end

    // Watchdog on cycles where neither side moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Present one value and hold it until the block takes it.
    task automatic send_value(input t_value v);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending and let every owed letter come out.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.letters_due.size() != 0);
    endtask

    initial begin
        t_value directed_values[] = '{
            12'd0,    12'd1,    12'd3,    12'd4,    12'd5,    12'd8,    12'd9,
            12'd10,   12'd40,   12'd49,   12'd90,   12'd99,   12'd400,  12'd444,
            12'd900,  12'd999,  12'd1000, 12'd1994, 12'd2730, 12'd3888, 12'd3999,
            12'd4000, 12'd4095, 12'd0,    12'd2
        };
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        int unsigned pick;
        int unsigned k;
        t_value      v;

        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values: extremes, every subtractive form, saturation, zero.
        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        wait_drained();

        // Random bursts with random gaps; a full drain every so often.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       v = '0;
                    1:       v = t_value'($urandom_range(4000, 4095));
                    2, 3:    v = t_value'($urandom_range(1, 99));
                    4, 5:    v = t_value'($urandom_range(3000, 3999));
                    default: v = t_value'($urandom_range(1, 3999));
                endcase
                send_value(v);
                sent++;
                if (sent % 120 == 0) begin
                    wait_drained();
                end
            end
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.letters_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> integer_to_roman_numeral.f
hw/rtl/i2r_pkg.sv
hw/rtl/i2r_cmpsub.sv
hw/rtl/integer_to_roman_numeral.sv
hw/rtl/i2r_checker.sv
test/tb_top.sv
